[src/mcts_pkg.sv]
// Shared types and constants for the moving average crossover trade signal core.
// Holds the channel word types, decision codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package mcts_pkg;

  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 32;
  localparam int WIN_W      = 9;
  // a window is at most 511 prices, so a sum needs 32 + 9 bits
  localparam int SUM_W      = PRICE_W + WIN_W;
  localparam int PROD_W     = SUM_W + WIN_W;
  localparam int MONEY_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int HIST_DEPTH_DEF = 256;

  localparam logic [WIN_W-1:0]   SHORT_WIN_RST = 9'd5;
  localparam logic [WIN_W-1:0]   LONG_WIN_RST  = 9'd20;
  localparam logic [MONEY_W-1:0] START_BAL_RST = 64'd42949672960000;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BAL = 2'd2;

  typedef enum logic [1:0] {
    DEC_WAIT  = 2'd0,
    DEC_LONG  = 2'd1,
    DEC_SHORT = 2'd2,
    DEC_HOLD  = 2'd3
  } decision_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } in_word_t;

  typedef struct packed {
    decision_t          decision;
    logic               bought;
    logic               sold;
    logic [MONEY_W-1:0] cash_now;
    logic [MONEY_W-1:0] held_now;
  } out_word_t;

  // products handed from the multiply stage to the account stage
  typedef struct packed {
    logic               full;
    logic [PROD_W-1:0]  lhs;
    logic [PROD_W-1:0]  rhs;
    logic [MONEY_W-1:0] cost;
    logic [QTY_W-1:0]   qty;
  } trade_req_t;

endpackage

`default_nettype wire

[src/mcts_ring.sv]
// Price history memory: one write port and two registered read ports.
// Read data is old data when a read and the write hit the same entry.
// Depends on mcts_pkg.
`default_nettype none

module mcts_ring #(
  parameter int DEPTH = mcts_pkg::HIST_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [mcts_pkg::PRICE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr_a,
  input  logic [AW-1:0]                rd_addr_b,
  output logic [mcts_pkg::PRICE_W-1:0] rd_data_a,
  output logic [mcts_pkg::PRICE_W-1:0] rd_data_b
);
  import mcts_pkg::*;

  logic [PRICE_W-1:0] mem [DEPTH];
  logic [PRICE_W-1:0] rd_a_r;
  logic [PRICE_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

[src/mcts_acct.sv]
// Simulated account: decides wait, long, short or hold and applies the trade to
// balance and position, both saturating. Depends on mcts_pkg.
`default_nettype none

module mcts_acct (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  mcts_pkg::trade_req_t            req,
  input  logic                            bal_ld,
  input  logic [mcts_pkg::MONEY_W-1:0]    bal_ld_val,
  output mcts_pkg::out_word_t             res
);
  import mcts_pkg::*;

  logic [MONEY_W-1:0] balance_r, balance_nxt;
  logic [MONEY_W-1:0] position_r, position_nxt;
  logic [MONEY_W:0]   bal_sum;
  logic [MONEY_W:0]   pos_sum;
  logic [MONEY_W-1:0] qty_ext;
  decision_t          dec;
  logic               buy, sell;

  assign qty_ext = {{(MONEY_W-QTY_W){1'b0}}, req.qty};
  assign bal_sum = {1'b0, balance_r} + {1'b0, req.cost};
  assign pos_sum = {1'b0, position_r} + {1'b0, qty_ext};

  always_comb begin
    if (!req.full) begin
      dec = DEC_WAIT;
    end else if (req.lhs > req.rhs) begin
      dec = DEC_LONG;
    end else if (req.lhs < req.rhs) begin
      dec = DEC_SHORT;
    end else begin
      dec = DEC_HOLD;
    end
    buy  = (dec == DEC_LONG) && (balance_r >= req.cost);
    sell = (dec == DEC_SHORT) && (position_r >= qty_ext);

    balance_nxt  = balance_r;
    position_nxt = position_r;
    if (buy) begin
      balance_nxt  = balance_r - req.cost;
      position_nxt = pos_sum[MONEY_W] ? '1 : pos_sum[MONEY_W-1:0];
    end else if (sell) begin
      balance_nxt  = bal_sum[MONEY_W] ? '1 : bal_sum[MONEY_W-1:0];
      position_nxt = position_r - qty_ext;
    end

    res.decision = dec;
    res.bought   = buy;
    res.sold     = sell;
    res.cash_now = balance_nxt;
    res.held_now = position_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      balance_r  <= START_BAL_RST;
      position_r <= '0;
    end else if (bal_ld) begin
      balance_r <= bal_ld_val;
    end else if (en) begin
      balance_r  <= balance_nxt;
      position_r <= position_nxt;
    end
  end

endmodule

`default_nettype wire

[src/ma_crossover_trade_signal_core.sv]
// Dual moving average crossover signal with a simulated account: top level.
// Uses mcts_pkg, mcts_ring and mcts_acct.
//
// Each accepted tick word (price, quantity, unsigned Q16.16) yields exactly one
// result word: WAIT until long_window prices are held, then LONG, SHORT or HOLD
// from comparing the short and long averages, plus the trade outcome and the
// account after it. The block takes one word per clock when the output is not
// stalled; each tick passes the p1, p2, trade request and output registers in
// that order. The sustained rate is set by the price memory, which takes the
// new price and gives the two prices leaving the windows in the same cycle,
// and by the account update, a read-modify-write of balance and position.
// Writing short_window or long_window empties the price history; writing
// start_balance loads the balance only. Write registers only while idle.
`default_nettype none

module ma_crossover_trade_signal_core #(
  parameter int HISTORY_DEPTH = mcts_pkg::HIST_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mcts_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mcts_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [mcts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mcts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mcts_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int DW = ((AW > WIN_W) ? AW : WIN_W) + 1;

  // slot written b pushes ago
  function automatic logic [AW-1:0] back_idx(input logic [AW-1:0] wp,
                                             input logic [WIN_W-1:0] b);
    logic [DW-1:0] diff;
    diff = DW'(wp) - DW'(b);
    if (diff[DW-1]) begin
      diff = diff + DW'(HISTORY_DEPTH);
    end
    return diff[AW-1:0];
  endfunction

  logic [WIN_W-1:0]   short_win_r, long_win_r;
  logic [WIN_W-1:0]   l_eff, s_eff;
  logic [WIN_W-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [SUM_W-1:0]   short_sum_r, long_sum_r;

  logic               v1_r, v2_r, v3_r, out_valid_r;
  logic               free1, free2, free3, adv_out;
  logic               en1, en2, en3, accept;

  logic [PRICE_W-1:0] p1_price_r, p2_price_r;
  logic [QTY_W-1:0]   p1_qty_r, p2_qty_r;
  logic               p1_drop_l_r, p1_drop_s_r, p1_full_r, p2_full_r;
  trade_req_t         req_r;
  out_word_t          out_data_r;
  out_word_t          acct_res;

  logic [PRICE_W-1:0] rd_long, rd_short;
  logic [SUM_W-1:0]   drop_l_val, drop_s_val, price_ext;
  logic               cfg_win_wr, cfg_bal_wr;

  // effective windows: long in 1..depth, short in 1..long
  always_comb begin
    if (long_win_r == '0) begin
      l_eff = WIN_W'(1);
    end else if (int'(long_win_r) > HISTORY_DEPTH) begin
      l_eff = WIN_W'(HISTORY_DEPTH);
    end else begin
      l_eff = long_win_r;
    end
    if (short_win_r == '0) begin
      s_eff = WIN_W'(1);
    end else if (short_win_r > l_eff) begin
      s_eff = l_eff;
    end else begin
      s_eff = short_win_r;
    end
  end

  // pipeline flow: a stage moves when the one after it is empty or moving
  assign adv_out  = !out_valid_r || !out_stall;
  assign free3    = !v3_r || adv_out;
  assign free2    = !v2_r || free3;
  assign free1    = !v1_r || free2;
  assign en3      = v3_r && adv_out;
  assign en2      = v2_r && free3;
  assign en1      = v1_r && free2;
  assign in_stall = !free1;
  assign accept   = in_valid && free1;

  assign fill_nxt = (fill_r < l_eff) ? fill_r + WIN_W'(1) : fill_r;
  assign wp_nxt   = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);

  assign cfg_win_wr = cfg_we && (cfg_idx == CFG_SHORT_WIN || cfg_idx == CFG_LONG_WIN);
  assign cfg_bal_wr = cfg_we && (cfg_idx == CFG_START_BAL);

  mcts_ring #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wp_r),
    .wr_data   (in_data.price),
    .rd_en     (accept),
    .rd_addr_a (back_idx(wp_r, l_eff)),
    .rd_addr_b (back_idx(wp_r, s_eff)),
    .rd_data_a (rd_long),
    .rd_data_b (rd_short)
  );

  assign drop_l_val = p1_drop_l_r ? {{WIN_W{1'b0}}, rd_long} : '0;
  assign drop_s_val = p1_drop_s_r ? {{WIN_W{1'b0}}, rd_short} : '0;
  assign price_ext  = {{WIN_W{1'b0}}, p1_price_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_win_r <= SHORT_WIN_RST;
      long_win_r  <= LONG_WIN_RST;
      fill_r      <= '0;
      wp_r        <= '0;
      short_sum_r <= '0;
      long_sum_r  <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept || (v1_r && !en1);
      v2_r        <= en1 || (v2_r && !en2);
      v3_r        <= en2 || (v3_r && !en3);
      out_valid_r <= en3 || (out_valid_r && !adv_out);
      if (accept) begin
        fill_r <= fill_nxt;
        wp_r   <= wp_nxt;
      end
      if (en1) begin
        long_sum_r  <= long_sum_r - drop_l_val + price_ext;
        short_sum_r <= short_sum_r - drop_s_val + price_ext;
      end
      // a window write empties the history
      if (cfg_win_wr) begin
        if (cfg_idx == CFG_SHORT_WIN) begin
          short_win_r <= cfg_wdata[WIN_W-1:0];
        end else begin
          long_win_r <= cfg_wdata[WIN_W-1:0];
        end
        fill_r      <= '0;
        wp_r        <= '0;
        short_sum_r <= '0;
        long_sum_r  <= '0;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_price_r  <= in_data.price;
      p1_qty_r    <= in_data.quantity;
      p1_drop_l_r <= (fill_r >= l_eff);
      p1_drop_s_r <= (fill_r >= s_eff);
      p1_full_r   <= (fill_nxt >= l_eff);
    end
    if (en1) begin
      p2_price_r <= p1_price_r;
      p2_qty_r   <= p1_qty_r;
      p2_full_r  <= p1_full_r;
    end
    if (en2) begin
      req_r.full <= p2_full_r;
      req_r.lhs  <= {{WIN_W{1'b0}}, short_sum_r} * {{SUM_W{1'b0}}, l_eff};
      req_r.rhs  <= {{WIN_W{1'b0}}, long_sum_r} * {{SUM_W{1'b0}}, s_eff};
      req_r.cost <= {{(MONEY_W-PRICE_W){1'b0}}, p2_price_r}
                    * {{(MONEY_W-QTY_W){1'b0}}, p2_qty_r};
      req_r.qty  <= p2_qty_r;
    end
    if (en3) begin
      out_data_r <= acct_res;
    end
  end

  mcts_acct u_acct (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en3),
    .req        (req_r),
    .bal_ld     (cfg_bal_wr),
    .bal_ld_val (cfg_wdata),
    .res        (acct_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[src/mcts_checker.sv]
// Port-level checks for the crossover trade signal core, bound to the top level.
// Depends on mcts_pkg and ma_crossover_trade_signal_core.
`default_nettype none

module mcts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input mcts_pkg::out_word_t out_data
);
  import mcts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  a_wait_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.decision == DEC_WAIT |-> !out_data.bought && !out_data.sold)
    else $error("trade reported on a wait decision");

  a_buy_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bought |-> out_data.decision == DEC_LONG && !out_data.sold)
    else $error("buy without a long decision");

  a_sell_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sold |-> out_data.decision == DEC_SHORT)
    else $error("sell without a short decision");

endmodule

bind ma_crossover_trade_signal_core mcts_checker u_mcts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
